### design/diff_drive_odometry_top_defines.svh
// Assertion macros used by the odometry queue.
`ifndef DIFF_DRIVE_ODOMETRY_TOP_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DDO_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ddo_pkg.sv
// Shared types, constants and helper functions of the odometry block.
`timescale 1ns / 1ps
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 24;

  localparam logic [15:0] WHEEL_RADIUS_RST = 16'd3277;
  localparam logic [23:0] INV_SEP_RST      = 24'd327680;
  localparam logic [23:0] SPEED_GAIN_RST   = 24'd1756878;

  localparam logic [23:0] INV_PI_Q24  = 24'd5340353;
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

  // Configuration register indexes
  localparam logic [1:0] CFG_WHEEL_RADIUS = 2'd0;
  localparam logic [1:0] CFG_INV_SEP      = 2'd1;
  localparam logic [1:0] CFG_SPEED_GAIN   = 2'd2;

  // Per-word results of the front end, consumed by the back end
  typedef struct packed {
    logic signed [31:0] lin;
    logic signed [31:0] turn;
    logic signed [31:0] lw;
    logic signed [31:0] rw;
    logic        [31:0] dyaw;
    logic        [23:0] dt;
  } ddo_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ddo_qstat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // atan(2^-i) on a 2^32 = 2*pi scale
  function automatic logic [31:0] atan_val(input logic [4:0] i);
    case (i)
      5'd0:  return 32'h20000000;
      5'd1:  return 32'h12E4051E;
      5'd2:  return 32'h09FB385B;
      5'd3:  return 32'h051111D4;
      5'd4:  return 32'h028B0D43;
      5'd5:  return 32'h0145D7E1;
      5'd6:  return 32'h00A2F61E;
      5'd7:  return 32'h00517C55;
      5'd8:  return 32'h0028BE53;
      5'd9:  return 32'h00145F2F;
      5'd10: return 32'h000A2F98;
      5'd11: return 32'h000517CC;
      5'd12: return 32'h00028BE6;
      5'd13: return 32'h000145F3;
      5'd14: return 32'h0000A2FA;
      5'd15: return 32'h0000517D;
      5'd16: return 32'h000028BE;
      5'd17: return 32'h0000145F;
      5'd18: return 32'h00000A30;
      5'd19: return 32'h00000518;
      5'd20: return 32'h0000028C;
      5'd21: return 32'h00000146;
      5'd22: return 32'h000000A3;
      5'd23: return 32'h00000051;
      5'd24: return 32'h00000029;
      5'd25: return 32'h00000014;
      5'd26: return 32'h0000000A;
      5'd27: return 32'h00000005;
      5'd28: return 32'h00000003;
      5'd29: return 32'h00000001;
      5'd30: return 32'h00000001;
      default: return 32'h00000000;
    endcase
  endfunction

endpackage

### design/ddo_front.sv
// Front end: config registers, input accept and speed/yaw-step multiply sequence.
`timescale 1ns / 1ps
module ddo_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [23:0]           cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [71:0]           in_tdata,
  input  ddo_pkg::ddo_qstat_t   q_stat,
  output logic                  q_push,
  output ddo_pkg::ddo_item_t    q_item
);
  import ddo_pkg::*;

  localparam logic [3:0] S_RG   = 4'd0;
  localparam logic [3:0] S_LW   = 4'd1;
  localparam logic [3:0] S_RW   = 4'd2;
  localparam logic [3:0] S_LIN  = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_TSEP = 4'd5;
  localparam logic [3:0] S_TURN = 4'd6;
  localparam logic [3:0] S_DT   = 4'd7;
  localparam logic [3:0] S_PI   = 4'd8;
  localparam logic [3:0] S_YAW  = 4'd9;
  localparam logic [3:0] S_HOLD = 4'd10;

  logic [15:0] wr_r;
  logic [23:0] isep_r;
  logic [23:0] sg_r;
  logic        busy_r;
  logic [3:0]  step_r;
  logic signed [23:0] l_r, r_r;
  logic [23:0] dt_r;
  logic [23:0] rg_r;
  logic signed [65:0] prod_r;
  logic signed [31:0] lin_r, turn_r, lw_r, rw_r;
  logic [31:0] dyaw_r;

  logic signed [40:0] op_a;
  logic signed [24:0] op_b;
  logic signed [24:0] diff_w, sum_w;
  logic signed [65:0] p16_w;

  assign diff_w = {r_r[23], r_r} - {l_r[23], l_r};
  assign sum_w  = {r_r[23], r_r} + {l_r[23], l_r};
  assign p16_w  = prod_r >>> 16;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_r)
      S_RG: begin
        op_a = {25'd0, wr_r};
        op_b = {1'b0, sg_r};
      end
      S_LW: begin
        op_a = -41'(l_r);
        op_b = {1'b0, sg_r};
      end
      S_RW: begin
        op_a = -41'(r_r);
        op_b = {1'b0, sg_r};
      end
      S_LIN: begin
        op_a = 41'(diff_w);
        op_b = {1'b0, rg_r};
      end
      S_SUM: begin
        op_a = 41'(sum_w);
        op_b = {1'b0, rg_r};
      end
      S_TSEP: begin
        op_a = p16_w[40:0];
        op_b = {1'b0, isep_r};
      end
      S_DT: begin
        op_a = 41'(turn_r);
        op_b = {1'b0, dt_r};
      end
      S_PI: begin
        op_a = p16_w[40:0];
        op_b = {1'b0, INV_PI_Q24};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign in_tready = !busy_r;
  assign q_push    = busy_r && (step_r == S_HOLD) && !q_stat.full;
  assign q_item    = '{lin: lin_r, turn: turn_r, lw: lw_r, rw: rw_r, dyaw: dyaw_r, dt: dt_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= WHEEL_RADIUS_RST;
      isep_r <= INV_SEP_RST;
      sg_r   <= SPEED_GAIN_RST;
      busy_r <= 1'b0;
      step_r <= S_RG;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_WHEEL_RADIUS: wr_r   <= cfg_wdata[15:0];
          CFG_INV_SEP:      isep_r <= cfg_wdata;
          CFG_SPEED_GAIN:   sg_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (!busy_r) begin
        if (in_tvalid) begin
          busy_r <= 1'b1;
          step_r <= S_RG;
        end
      end else if (step_r == S_HOLD) begin
        if (!q_stat.full) begin
          busy_r <= 1'b0;
        end
      end else begin
        step_r <= step_r + 4'd1;
      end
    end
  end

  // datapath: product of the previous step is captured here
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (!busy_r && in_tvalid) begin
      l_r  <= in_tdata[23:0];
      r_r  <= in_tdata[47:24];
      dt_r <= in_tdata[71:48];
    end
    if (busy_r) begin
      case (step_r)
        S_LW:   rg_r   <= prod_r[39:16];
        S_RW:   lw_r   <= sat32(p16_w);
        S_LIN:  rw_r   <= sat32(p16_w);
        S_SUM:  lin_r  <= sat32(prod_r >>> 17);
        S_TURN: turn_r <= sat32(p16_w);
        S_YAW:  dyaw_r <= prod_r[49:18];
        default: ;
      endcase
    end
  end

endmodule

### design/ddo_queue.sv
// Two-word queue between front and back ends.
`timescale 1ns / 1ps
`include "diff_drive_odometry_top_defines.svh"
module ddo_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ddo_pkg::ddo_item_t   din,
  input  logic                 pop,
  output ddo_pkg::ddo_item_t   dout,
  output ddo_pkg::ddo_qstat_t  stat
);
  import ddo_pkg::*;

  ddo_item_t  ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign dout       = ent_r[rp_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= din;
  end

  `DDO_ASSERT_IMPL(a_q_no_ovf, push, cnt_r != 2'd2, "queue push while full")
  `DDO_ASSERT_IMPL(a_q_no_unf, pop, cnt_r != 2'd0, "queue pop while empty")
  `DDO_ASSERT_IMPL(a_q_cnt_max, 1'b1, cnt_r != 2'd3, "queue count out of range")
  `DDO_ASSERT_NEXT(a_q_ptrs, cnt_r == 2'd0 && !push, wp_r == rp_r, "pointers split when empty")

endmodule

### design/ddo_cordic.sv
// Iterative CORDIC rotator: sin/cos of a binary angle, one step per cycle.
`timescale 1ns / 1ps
module ddo_cordic #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);
  import ddo_pkg::*;

  localparam int CW = $clog2(CORDIC_STEPS + 1);
  localparam logic signed [33:0] ONE = 34'sd1073741824;

  logic          run_r, done_r, neg_r;
  logic [CW-1:0] cnt_r;
  logic signed [33:0] x_r, y_r, a_r;
  logic signed [31:0] sa_w;
  logic               fold_w;
  logic signed [33:0] dx_w, dy_w, at_w, xc_w, yc_w;

  assign sa_w   = angle;
  assign fold_w = (sa_w > 32'sd1073741824) || (sa_w < -32'sd1073741824);
  assign dx_w   = y_r >>> cnt_r;
  assign dy_w   = x_r >>> cnt_r;
  assign at_w   = {2'b00, atan_val(5'(cnt_r))};

  assign xc_w  = (x_r > ONE) ? ONE : ((x_r < -ONE) ? -ONE : x_r);
  assign yc_w  = (y_r > ONE) ? ONE : ((y_r < -ONE) ? -ONE : y_r);
  assign cos_o = neg_r ? 32'(-xc_w) : 32'(xc_w);
  assign sin_o = neg_r ? 32'(-yc_w) : 32'(yc_w);
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        if (cnt_r == CW'(CORDIC_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= 34'(CORDIC_GAIN);
      y_r   <= '0;
      neg_r <= fold_w;
      a_r   <= fold_w ? 34'(signed'(angle - 32'h80000000)) : 34'(sa_w);
    end else if (run_r) begin
      if (a_r >= 0) begin
        x_r <= x_r - dx_w;
        y_r <= y_r + dy_w;
        a_r <= a_r - at_w;
      end else begin
        x_r <= x_r + dx_w;
        y_r <= y_r - dy_w;
        a_r <= a_r + at_w;
      end
    end
  end

endmodule

### design/ddo_back.sv
// Back end: heading, position and wheel angle integration, quaternion, result register.
`timescale 1ns / 1ps
module ddo_back #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ddo_pkg::ddo_qstat_t  q_stat,
  output logic                 q_pop,
  input  ddo_pkg::ddo_item_t   q_item,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [383:0]         out_tdata
);
  import ddo_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_HEAD = 3'd1;
  localparam logic [2:0] B_C1   = 3'd2;
  localparam logic [2:0] B_MUL  = 3'd3;
  localparam logic [2:0] B_C2   = 3'd4;
  localparam logic [2:0] B_OUT  = 3'd5;

  localparam logic [2:0] K_LC = 3'd0;
  localparam logic [2:0] K_LS = 3'd1;
  localparam logic [2:0] K_X  = 3'd2;
  localparam logic [2:0] K_Y  = 3'd3;
  localparam logic [2:0] K_LA = 3'd4;
  localparam logic [2:0] K_RA = 3'd5;
  localparam logic [2:0] K_END = 3'd6;

  logic [2:0] st_r, k_r;
  ddo_item_t  it_r;
  logic [31:0] head_r, new_head_w;
  logic signed [31:0] x_r, y_r, c_r, s_r, qz_r, qw_r;
  logic signed [47:0] la_r, ra_r;
  logic signed [33:0] tc_r, ts_r;
  logic signed [65:0] prod_r;
  logic signed [33:0] op_a;
  logic signed [31:0] op_b;
  logic               cstart;
  logic [31:0]        cangle;
  logic               cdone;
  logic signed [31:0] csin, ccos;
  logic signed [65:0] p24_w;

  assign new_head_w = head_r + it_r.dyaw;
  assign cstart = (st_r == B_HEAD) || (st_r == B_MUL && k_r == K_END);
  assign cangle = (st_r == B_HEAD) ? {new_head_w[30:0], 1'b0} : head_r;
  assign p24_w  = prod_r >>> 24;
  assign q_pop  = (st_r == B_IDLE) && !q_stat.empty;

  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cstart),
    .angle (cangle),
    .done  (cdone),
    .sin_o (csin),
    .cos_o (ccos)
  );

  always_comb begin
    op_a = '0;
    op_b = '0;
    if (st_r == B_MUL) begin
      case (k_r)
        K_LC: begin op_a = 34'(it_r.lin); op_b = c_r; end
        K_LS: begin op_a = 34'(it_r.lin); op_b = s_r; end
        K_X:  begin op_a = tc_r; op_b = {8'd0, it_r.dt}; end
        K_Y:  begin op_a = ts_r; op_b = {8'd0, it_r.dt}; end
        K_LA: begin op_a = 34'(it_r.lw); op_b = {8'd0, it_r.dt}; end
        K_RA: begin op_a = 34'(it_r.rw); op_b = {8'd0, it_r.dt}; end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= B_IDLE;
      k_r    <= K_LC;
      head_r <= '0;
      x_r    <= '0;
      y_r    <= '0;
      la_r   <= '0;
      ra_r   <= '0;
    end else begin
      case (st_r)
        B_IDLE: if (!q_stat.empty) st_r <= B_HEAD;
        B_HEAD: begin
          head_r <= new_head_w;
          st_r   <= B_C1;
        end
        B_C1: if (cdone) begin
          k_r  <= K_LC;
          st_r <= B_MUL;
        end
        B_MUL: begin
          k_r <= k_r + 3'd1;
          case (k_r)
            K_Y:   x_r  <= sat32(66'(x_r) + p24_w);
            K_LA:  y_r  <= sat32(66'(y_r) + p24_w);
            K_RA:  la_r <= la_r + 48'(p24_w);
            K_END: begin
              ra_r <= ra_r + 48'(p24_w);
              st_r <= B_C2;
            end
            default: ;
          endcase
        end
        B_C2: if (cdone) st_r <= B_OUT;
        B_OUT: if (out_tready) st_r <= B_IDLE;
        default: st_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (q_pop) it_r <= q_item;
    if (st_r == B_C1 && cdone) begin
      c_r <= ccos;
      s_r <= csin;
    end
    if (st_r == B_MUL && k_r == K_LS) tc_r <= prod_r[63:30];
    if (st_r == B_MUL && k_r == K_X)  ts_r <= prod_r[63:30];
    if (st_r == B_C2 && cdone) begin
      qz_r <= csin;
      qw_r <= ccos;
    end
  end

  assign out_tvalid = (st_r == B_OUT);
  assign out_tdata  = {ra_r, la_r, it_r.rw, it_r.lw, qw_r, qz_r,
                       it_r.turn, it_r.lin, head_r, y_r, x_r};

endmodule

### design/diff_drive_odometry_top.sv
// Top level of the differential-drive odometry block.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------
//  in_     | in  | in_tvalid/in_tready  | 72-bit word: speeds, step time
//  out_    | out | out_tvalid/out_tready| 384-bit word: pose, rates, angles
//  cfg_    | in  | cfg_wr_en            | cfg_index, cfg_wdata
//
// Front end computes eight products per word on one 41x25 multiplier.
// Back end makes two CORDIC runs per word plus six multiplies on one
// 34x32 multiplier.
// A two-word queue lets the front accept new words while a result waits.
// Reset: synchronous, active low; clears state and restores register defaults.
// A stalled output holds the back end; the front keeps filling the queue.
`timescale 1ns / 1ps
module diff_drive_odometry_top #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [23:0] left_speed, [47:24] right_speed, [71:48] step_time
  input  logic [71:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, heading, lin_speed, turn_rate, quat_z, quat_w,
  // left_wheel_rate, right_wheel_rate (32 each), left/right_wheel_angle (48 each)
  output logic [383:0] out_tdata
);
  import ddo_pkg::*;

  ddo_qstat_t q_stat;
  logic       q_push, q_pop;
  ddo_item_t  q_din, q_dout;

  ddo_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_item    (q_din)
  );

  ddo_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  // back end: heading first, then x/y with the new yaw, then quaternion
  ddo_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .q_item     (q_dout),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
